// ----- rtl/analog_axis_conditioner_core_macros.svh -----
// Assertion macros shared by the conditioner RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ANALOG_AXIS_CONDITIONER_CORE_MACROS_SVH
`define ANALOG_AXIS_CONDITIONER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AAC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AAC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/aac_pkg.sv -----
// Shared constants and types for the analog axis conditioner.
// No dependencies; imported by every module of the block.
`default_nettype none

package aac_pkg;

   // Sample and filter widths.
   localparam int SAMPLE_BITS   = 12;
   localparam int FRACTION_BITS = 8;
   localparam int ALPHA_BITS    = 8;
   localparam int ACC_BITS      = SAMPLE_BITS + FRACTION_BITS;
   localparam int PROD_BITS     = ACC_BITS + ALPHA_BITS;
   localparam int NUM_BITS      = 2 * SAMPLE_BITS;
   localparam int DIV_COUNT_BITS = $clog2(SAMPLE_BITS);

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE    = '1;
   localparam logic [SAMPLE_BITS-1:0] QUARTER_SCALE = FULL_SCALE / 4;
   localparam logic [ALPHA_BITS-1:0]  DEFAULT_GAIN  = '1;

   // Axis mapping: level * 65535 / 4095 = level * 16 + level / 273.
   // The quotient by 273 comes from a reciprocal multiply that is exact
   // for every 12-bit level.
   localparam int AXIS_BITS       = 16;
   localparam int AXIS_GAIN_SHIFT = AXIS_BITS - SAMPLE_BITS;
   localparam int AXIS_RECIP_SHIFT = 20;
   localparam int AXIS_PROD_BITS  = SAMPLE_BITS + 12;
   localparam int AXIS_QUO_BITS   = AXIS_PROD_BITS - AXIS_RECIP_SHIFT;
   localparam logic [AXIS_PROD_BITS-1:0] AXIS_RECIP = 24'd3841;

   // Result transaction layout.
   localparam int RSP_BITS = 32;
   localparam int RSP_PAD_BITS = RSP_BITS - AXIS_BITS - SAMPLE_BITS - 1;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RANGE_MIN       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RANGE_MAX       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SMOOTHING_ALPHA = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INVERT_LEVEL    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ACTIVITY_MODE   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REST_BASELINE   = 3'd5;

   localparam logic [SAMPLE_BITS-1:0] RESET_RANGE_MIN     = '0;
   localparam logic [SAMPLE_BITS-1:0] RESET_RANGE_MAX     = '1;
   localparam logic [SAMPLE_BITS-1:0] RESET_REST_BASELINE = 12'd2048;

   // Queue between front and back.
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] range_min;
      logic [SAMPLE_BITS-1:0] range_max;
      logic [ALPHA_BITS-1:0]  smoothing_alpha;
      logic                   invert_level;
      logic                   activity_mode;
      logic [SAMPLE_BITS-1:0] rest_baseline;
   } cfg_type;

   typedef struct packed {
      logic                   valid;
      logic [SAMPLE_BITS-1:0] level;
   } push_type;

endpackage

`default_nettype wire

// ----- rtl/aac_front.sv -----
// Front end: accepts samples, classifies them against the window and
// stretches in-window samples with a restoring divider. Uses aac_pkg.
`default_nettype none
`include "analog_axis_conditioner_core_macros.svh"

module aac_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire aac_pkg::cfg_type              cfg,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [aac_pkg::SAMPLE_BITS-1:0] sample,
   output aac_pkg::push_type                  push,
   input  wire logic                          push_ready
);
   import aac_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [SAMPLE_BITS-1:0]    value_ff, value_in;
   logic [SAMPLE_BITS-1:0]    rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]    num_ff, num_in;
   logic [SAMPLE_BITS-1:0]    den_ff, den_in;
   logic [DIV_COUNT_BITS-1:0] count_ff, count_in;

   logic                      accept;
   logic [SAMPLE_BITS-1:0]    offset;
   logic [NUM_BITS-1:0]       numerator;
   logic [SAMPLE_BITS:0]      trial;
   logic [SAMPLE_BITS:0]      trial_diff;
   logic                      qbit;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Offset into the window scaled by full scale, without a multiplier.
   assign offset    = sample - cfg.range_min;
   assign numerator = {offset, {SAMPLE_BITS{1'b0}}} - {{SAMPLE_BITS{1'b0}}, offset};

   // One restoring divider step: bring down the next numerator bit.
   assign trial      = {rem_ff, num_ff[SAMPLE_BITS-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign qbit       = (trial >= {1'b0, den_ff});

   // Sequencer for classification, division and hand-off.
   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cfg.range_max <= cfg.range_min) begin
                  value_in = sample;
                  state_in = ST_PUSH;
               end else if (sample <= cfg.range_min) begin
                  value_in = '0;
                  state_in = ST_PUSH;
               end else if (sample >= cfg.range_max) begin
                  value_in = FULL_SCALE;
                  state_in = ST_PUSH;
               end else begin
                  den_in   = cfg.range_max - cfg.range_min;
                  rem_in   = numerator[NUM_BITS-1:SAMPLE_BITS];
                  num_in   = numerator[SAMPLE_BITS-1:0];
                  count_in = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in   = qbit ? trial_diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            num_in   = {num_ff[SAMPLE_BITS-2:0], 1'b0};
            value_in = {value_ff[SAMPLE_BITS-2:0], qbit};
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_COUNT_BITS'(SAMPLE_BITS - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign push.valid = (state_ff == ST_PUSH);
   assign push.level = value_ff;

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
   end

   `AAC_ASSERT_IMP(a_div_rem_below_den, clock, reset, state_ff == ST_DIV,
                   rem_ff < den_ff, "divider remainder reached the divisor")

endmodule

`default_nettype wire

// ----- rtl/aac_queue.sv -----
// Two-entry queue carrying stretched levels from the front to the back.
// Uses aac_pkg for its depth and entry type.
`default_nettype none
`include "analog_axis_conditioner_core_macros.svh"

module aac_queue (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire aac_pkg::push_type               push,
   output logic                                 push_ready,
   output logic                                 pop_valid,
   output logic [aac_pkg::SAMPLE_BITS-1:0]      pop_level,
   input  wire logic                            pop_ready
);
   import aac_pkg::*;

   logic [SAMPLE_BITS-1:0]      mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = (count_ff != QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_level  = mem[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.level;
      end
   end

   `AAC_ASSERT_IMP(a_count_in_range, clock, reset, 1'b1,
                   count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH), "queue count beyond depth")
   `AAC_ASSERT_NXT(a_pop_only_not_empty, clock, reset, count_ff == '0 && !push.valid,
                   count_ff == '0, "queue count moved without a push")

endmodule

`default_nettype wire

// ----- rtl/aac_back.sv -----
// Back end: exponential smoothing, inversion, axis mapping and activity
// flag, with the result register toward the output. Uses aac_pkg.
`default_nettype none
`include "analog_axis_conditioner_core_macros.svh"

module aac_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire aac_pkg::cfg_type                cfg,
   input  wire logic                            pop_valid,
   input  wire logic [aac_pkg::SAMPLE_BITS-1:0] pop_level,
   output logic                                 pop_ready,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [aac_pkg::RSP_BITS-1:0]         rsp_tdata
);
   import aac_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_UPD   = 3'd2;
   localparam logic [2:0] ST_LEVEL = 3'd3;
   localparam logic [2:0] ST_AXIS  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [ACC_BITS-1:0]       acc_ff, acc_in;
   logic                      seeded_ff, seeded_in;
   logic [ACC_BITS-1:0]       target_ff;
   logic                      up_ff;
   logic [PROD_BITS-1:0]      prod_ff;
   logic [SAMPLE_BITS-1:0]    level_ff;
   logic [AXIS_PROD_BITS-1:0] recip_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]       rsp_data_ff;

   logic [ALPHA_BITS-1:0]     gain;
   logic                      up;
   logic [ACC_BITS-1:0]       diff;
   logic [ACC_BITS-1:0]       step;
   logic [SAMPLE_BITS-1:0]    raw_level;
   logic [AXIS_BITS-1:0]      axis_sum;
   logic [AXIS_BITS-1:0]      axis_value;
   logic [SAMPLE_BITS-1:0]    base_dist;
   logic                      active;
   logic                      load;

   assign pop_ready = (state_ff == ST_IDLE);

   // Filter datapath: gain times distance, then a truncated step.
   assign gain      = (cfg.smoothing_alpha == '0) ? DEFAULT_GAIN : cfg.smoothing_alpha;
   assign up        = (target_ff > acc_ff);
   assign diff      = up ? (target_ff - acc_ff) : (acc_ff - target_ff);
   assign step      = prod_ff[PROD_BITS-1:ALPHA_BITS];
   assign raw_level = acc_ff[ACC_BITS-1:FRACTION_BITS];

   // Axis value: level * 16 plus level / 273, then offset by half range.
   assign axis_sum   = {level_ff, {AXIS_GAIN_SHIFT{1'b0}}}
                     + {{(AXIS_BITS-AXIS_QUO_BITS){1'b0}},
                        recip_ff[AXIS_PROD_BITS-1:AXIS_RECIP_SHIFT]};
   assign axis_value = {~axis_sum[AXIS_BITS-1], axis_sum[AXIS_BITS-2:0]};

   // Activity flag.
   assign base_dist = (level_ff > cfg.rest_baseline) ? (level_ff - cfg.rest_baseline)
                                                     : (cfg.rest_baseline - level_ff);
   assign active = cfg.activity_mode ? (base_dist > QUARTER_SCALE)
                                     : (level_ff > QUARTER_SCALE);

   assign load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Sequencer for one filter update and its result.
   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      seeded_in = seeded_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (!seeded_ff) begin
               acc_in = target_ff;
            end else if (up_ff) begin
               acc_in = acc_ff + step;
            end else begin
               acc_in = acc_ff - step;
            end
            seeded_in = 1'b1;
            state_in  = ST_LEVEL;
         end
         ST_LEVEL: begin
            state_in = ST_AXIS;
         end
         ST_AXIS: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result register frees once its transaction completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers, each loaded in its own stage of the sequence.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && pop_valid) begin
         target_ff <= {pop_level, {FRACTION_BITS{1'b0}}};
      end
      if (state_ff == ST_MUL) begin
         up_ff   <= up;
         prod_ff <= PROD_BITS'(gain) * PROD_BITS'(diff);
      end
      if (state_ff == ST_LEVEL) begin
         level_ff <= cfg.invert_level ? (FULL_SCALE - raw_level) : raw_level;
      end
      if (state_ff == ST_AXIS) begin
         recip_ff <= AXIS_PROD_BITS'(level_ff) * AXIS_RECIP;
      end
      if (load) begin
         rsp_data_ff <= {{RSP_PAD_BITS{1'b0}}, active, level_ff, axis_value};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `AAC_ASSERT_NXT(a_seeded_after_update, clock, reset, state_ff == ST_UPD,
                   seeded_ff, "filter not seeded after an update")
   `AAC_ASSERT_IMP(a_load_needs_slot, clock, reset, state_ff == ST_DONE && rsp_valid_ff
                   && !rsp_tready, !load, "result register overwritten while held")

endmodule

`default_nettype wire

// ----- rtl/analog_axis_conditioner_core.sv -----
// Top level of the analog axis conditioner: configuration registers and
// the front, queue and back stages. Depends on aac_pkg and its submodules.
`default_nettype none

// The conditioner takes one 12-bit sample per req transaction and returns
// one rsp transaction with the axis value, the smoothed level and the
// activity flag. A sample inside the sensitivity window passes through a
// twelve-step restoring divider, so the front spends longer on it than on
// a sample that is clamped or passed through, and takes no new sample
// until it has pushed the last. The back steps through the filter update
// and axis mapping for each sample, so a run of clamped samples is paced
// by the back. A two-entry queue lets the front take the next sample while
// the back works, and the result register lets the back continue while a
// result waits. Write configuration only while no sample is in flight.
module analog_axis_conditioner_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Sample input.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [15:0]                         req_tdata,  // [11:0] sample
   // Result output.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [15:0] axis_value, [27:16] level, [28] active
   output logic [aac_pkg::RSP_BITS-1:0]             rsp_tdata,
   // Configuration writes.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [aac_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [aac_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import aac_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   push_type               push;
   logic                   push_ready;
   logic                   pop_valid;
   logic                   pop_ready;
   logic [SAMPLE_BITS-1:0] pop_level;

   assign csr_ready = 1'b1;

   // Register file write; indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RANGE_MIN:       cfg_in.range_min       = csr_data[SAMPLE_BITS-1:0];
            REG_RANGE_MAX:       cfg_in.range_max       = csr_data[SAMPLE_BITS-1:0];
            REG_SMOOTHING_ALPHA: cfg_in.smoothing_alpha = csr_data[ALPHA_BITS-1:0];
            REG_INVERT_LEVEL:    cfg_in.invert_level    = csr_data[0];
            REG_ACTIVITY_MODE:   cfg_in.activity_mode   = csr_data[0];
            REG_REST_BASELINE:   cfg_in.rest_baseline   = csr_data[SAMPLE_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_min       <= RESET_RANGE_MIN;
         cfg_ff.range_max       <= RESET_RANGE_MAX;
         cfg_ff.smoothing_alpha <= '0;
         cfg_ff.invert_level    <= 1'b0;
         cfg_ff.activity_mode   <= 1'b0;
         cfg_ff.rest_baseline   <= RESET_REST_BASELINE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   aac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .push       (push),
      .push_ready (push_ready)
   );

   aac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_level  (pop_level),
      .pop_ready  (pop_ready)
   );

   aac_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_level  (pop_level),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
